// ===== rtl/qfed_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// Query field extract/decode package
// Shared widths, character codes, parse phases, status codes and register
// indexes of the query field extract/decode unit.
// ----------------------------------------------------------------------------
package qfed_pkg;

    localparam int BYTE_W     = 8;
    localparam int LENGTH_W   = 4;
    localparam int CAPACITY_W = 16;
    localparam int KEY_TEXT_W = 64;
    localparam int CFG_DATA_W = 64;
    localparam int CFG_INDEX_W = 2;
    localparam int STATUS_W   = 2;
    localparam int NIBBLE_W   = 4;

    localparam logic [BYTE_W-1:0] CHAR_END   = 8'h00;
    localparam logic [BYTE_W-1:0] CHAR_PLUS  = 8'h2B;
    localparam logic [BYTE_W-1:0] CHAR_PCT   = 8'h25;
    localparam logic [BYTE_W-1:0] CHAR_AMP   = 8'h26;
    localparam logic [BYTE_W-1:0] CHAR_EQ    = 8'h3D;
    localparam logic [BYTE_W-1:0] CHAR_SPACE = 8'h20;

    localparam logic [CAPACITY_W-1:0] CAPACITY_RESET = 16'd256;

    typedef enum logic [2:0] {
        PH_KEY,
        PH_SKIP,
        PH_VALUE,
        PH_ESC_HI,
        PH_ESC_LO,
        PH_DONE
    } phase_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_NOT_FOUND = 2'd0,
        ST_FOUND     = 2'd1,
        ST_ERROR     = 2'd2
    } status_t;

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_KEY_TEXT       = 2'd0,
        REG_KEY_LENGTH     = 2'd1,
        REG_VALUE_CAPACITY = 2'd2
    } reg_index_t;

    typedef enum logic {
        KIND_BYTE   = 1'b0,
        KIND_STATUS = 1'b1
    } kind_t;

    // Hex digit decode: valid flag and nibble value
    typedef struct packed {
        logic                ok;
        logic [NIBBLE_W-1:0] value;
    } nibble_t;

    function automatic nibble_t nibble_of(input logic [BYTE_W-1:0] b);
        nibble_t n;
        n.ok    = 1'b1;
        n.value = '0;
        if (b >= 8'h30 && b <= 8'h39)
        begin
            n.value = NIBBLE_W'(b - 8'h30);
        end
        else if (b >= 8'h61 && b <= 8'h66)
        begin
            n.value = NIBBLE_W'(b - 8'h57);
        end
        else if (b >= 8'h41 && b <= 8'h46)
        begin
            n.value = NIBBLE_W'(b - 8'h37);
        end
        else
        begin
            n.ok = 1'b0;
        end
        return n;
    endfunction

endpackage
`default_nettype wire

// ===== rtl/qfed_query_if.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// Query byte channel
// Valid/ready channel carrying one query string byte per word.
// ----------------------------------------------------------------------------
interface qfed_query_if;
    logic                        valid;
    logic                        ready;
    logic [qfed_pkg::BYTE_W-1:0] query_byte;

    modport source (output valid, output query_byte, input ready);
    modport sink   (input valid, input query_byte, output ready);
endinterface
`default_nettype wire

// ===== rtl/qfed_result_if.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// Result channel
// Valid/ready channel carrying a decoded value byte or a final status word.
// ----------------------------------------------------------------------------
interface qfed_result_if;
    logic                          valid;
    logic                          ready;
    logic                          result_kind;
    logic [qfed_pkg::BYTE_W-1:0]   value_byte;
    logic [qfed_pkg::STATUS_W-1:0] match_status;

    modport source (output valid, output result_kind, output value_byte,
                    output match_status, input ready);
    modport sink   (input valid, input result_kind, input value_byte,
                    input match_status, output ready);
endinterface
`default_nettype wire

// ===== rtl/query_field_extract_decode_unit.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// Query field extract/decode unit
// Scans a zero-terminated URL query string, selects the first pair whose key
// matches the configured key and streams its percent-decoded value bytes,
// followed by one final status word.
// ----------------------------------------------------------------------------
// The unit takes at most one query byte per cycle and gives at most one result word
// per byte, in the cycle after the byte is accepted. Each byte is handled by a
// single registered update of the parse state; the result register lets a new
// byte be accepted in the same cycle that the previous result word is taken,
// so a stream sustains one byte per clock while the result side keeps up.
// Value bytes come out as they are decoded; a status word ends each run
// (not found, found, error), and after an error the consumer drops the value
// bytes it already received. Bytes after the status are consumed silently up
// to and including the terminating zero byte. Write the key and capacity
// registers only while no string is in progress.
// ----------------------------------------------------------------------------
module query_field_extract_decode_unit #(
    parameter int KEY_MAX_BYTES = 8
) (
    input  wire logic                                 clk,
    input  wire logic                                 rst_n,
    qfed_query_if.sink                                query,
    qfed_result_if.source                             result,
    input  wire logic                                 cfg_write,
    input  wire logic [qfed_pkg::CFG_INDEX_W-1:0]     cfg_index,
    input  wire logic [qfed_pkg::CFG_DATA_W-1:0]      cfg_data
);

    localparam int KEY_W = 8 * KEY_MAX_BYTES;

    // configuration registers
    logic [KEY_W-1:0]                    key_text_reg;
    logic [qfed_pkg::LENGTH_W-1:0]       key_length_reg;
    logic [qfed_pkg::CAPACITY_W-1:0]     value_capacity_reg;

    // parse state
    qfed_pkg::phase_t                    phase_reg, phase_next;
    logic [qfed_pkg::LENGTH_W-1:0]       key_position_reg, key_position_next;
    logic                                key_mismatch_reg, key_mismatch_next;
    logic [qfed_pkg::CAPACITY_W-1:0]     value_count_reg, value_count_next;
    logic [qfed_pkg::NIBBLE_W-1:0]       high_nibble_reg, high_nibble_next;

    // result register
    logic                                result_valid_reg;
    logic                                result_kind_reg, result_kind_next;
    logic [qfed_pkg::BYTE_W-1:0]         value_byte_reg, value_byte_next;
    logic [qfed_pkg::STATUS_W-1:0]       match_status_reg, match_status_next;
    logic                                emit_next;

    logic                                accept;
    logic [qfed_pkg::BYTE_W-1:0]         b;
    logic [qfed_pkg::BYTE_W-1:0]         key_byte;
    logic                                key_hit;
    qfed_pkg::nibble_t                   nib;
    logic [qfed_pkg::BYTE_W-1:0]         plain_byte;
    logic [qfed_pkg::BYTE_W-1:0]         esc_byte;
    logic [qfed_pkg::CAPACITY_W-1:0]     cap_eff;
    logic [qfed_pkg::CAPACITY_W:0]       count_plus;
    logic                                full;

    assign query.ready = !result_valid_reg || result.ready;
    assign accept      = query.valid && query.ready;
    assign b           = query.query_byte;

    assign result.valid        = result_valid_reg;
    assign result.result_kind  = result_kind_reg;
    assign result.value_byte   = value_byte_reg;
    assign result.match_status = match_status_reg;

    // select the key byte at the current match position
    always_comb
    begin
        key_byte = '0;
        for (int i = 0; i < KEY_MAX_BYTES; i++)
        begin
            if (key_position_reg == qfed_pkg::LENGTH_W'(i))
            begin
                key_byte = key_text_reg[8*i +: 8];
            end
        end
    end

    assign key_hit = (key_position_reg < key_length_reg)
                  && ({1'b0, key_position_reg} < (qfed_pkg::LENGTH_W+1)'(KEY_MAX_BYTES))
                  && (key_byte == b);

    assign nib        = qfed_pkg::nibble_of(b);
    assign plain_byte = (b == qfed_pkg::CHAR_PLUS) ? qfed_pkg::CHAR_SPACE : b;
    assign esc_byte   = {high_nibble_reg, nib.value};
    assign cap_eff    = (value_capacity_reg == '0) ? qfed_pkg::CAPACITY_W'(1)
                                                   : value_capacity_reg;
    assign count_plus = {1'b0, value_count_reg} + (qfed_pkg::CAPACITY_W+1)'(1);
    assign full       = count_plus >= {1'b0, cap_eff};

    // next parse state
    always_comb
    begin
        phase_next        = phase_reg;
        key_position_next = key_position_reg;
        key_mismatch_next = key_mismatch_reg;
        value_count_next  = value_count_reg;
        high_nibble_next  = high_nibble_reg;
        if (b == qfed_pkg::CHAR_END)
        begin
            // end of string restarts the parse from any phase
            phase_next        = qfed_pkg::PH_KEY;
            key_position_next = '0;
            key_mismatch_next = 1'b0;
            value_count_next  = '0;
            high_nibble_next  = '0;
        end
        else
        begin
            unique case (phase_reg)
                qfed_pkg::PH_KEY:
                begin
                    if (b == qfed_pkg::CHAR_AMP)
                    begin
                        key_position_next = '0;
                        key_mismatch_next = 1'b0;
                    end
                    else if (b == qfed_pkg::CHAR_EQ)
                    begin
                        if (!key_mismatch_reg && key_position_reg == key_length_reg)
                        begin
                            phase_next       = qfed_pkg::PH_VALUE;
                            value_count_next = '0;
                        end
                        else
                        begin
                            phase_next = qfed_pkg::PH_SKIP;
                        end
                    end
                    else if (key_hit)
                    begin
                        key_position_next = key_position_reg + qfed_pkg::LENGTH_W'(1);
                    end
                    else
                    begin
                        key_mismatch_next = 1'b1;
                    end
                end
                qfed_pkg::PH_SKIP:
                begin
                    if (b == qfed_pkg::CHAR_AMP)
                    begin
                        phase_next        = qfed_pkg::PH_KEY;
                        key_position_next = '0;
                        key_mismatch_next = 1'b0;
                    end
                end
                qfed_pkg::PH_VALUE:
                begin
                    if (b == qfed_pkg::CHAR_AMP)
                    begin
                        phase_next = qfed_pkg::PH_DONE;
                    end
                    else if (b == qfed_pkg::CHAR_PCT)
                    begin
                        phase_next = qfed_pkg::PH_ESC_HI;
                    end
                    else if (full)
                    begin
                        phase_next = qfed_pkg::PH_DONE;
                    end
                    else
                    begin
                        value_count_next = count_plus[qfed_pkg::CAPACITY_W-1:0];
                    end
                end
                qfed_pkg::PH_ESC_HI:
                begin
                    if (nib.ok)
                    begin
                        high_nibble_next = nib.value;
                        phase_next       = qfed_pkg::PH_ESC_LO;
                    end
                    else
                    begin
                        phase_next = qfed_pkg::PH_DONE;
                    end
                end
                qfed_pkg::PH_ESC_LO:
                begin
                    if (!nib.ok || esc_byte == qfed_pkg::CHAR_END || full)
                    begin
                        phase_next = qfed_pkg::PH_DONE;
                    end
                    else
                    begin
                        phase_next       = qfed_pkg::PH_VALUE;
                        value_count_next = count_plus[qfed_pkg::CAPACITY_W-1:0];
                    end
                end
                qfed_pkg::PH_DONE:
                begin
                end
                default:
                begin
                    phase_next = qfed_pkg::PH_DONE;
                end
            endcase
        end
    end

    // result word
    always_comb
    begin
        emit_next         = 1'b0;
        result_kind_next  = qfed_pkg::KIND_STATUS;
        value_byte_next   = '0;
        match_status_next = qfed_pkg::ST_NOT_FOUND;
        unique case (phase_reg) inside
            qfed_pkg::PH_KEY, qfed_pkg::PH_SKIP:
            begin
                if (b == qfed_pkg::CHAR_END)
                begin
                    emit_next = 1'b1;
                end
            end
            qfed_pkg::PH_VALUE:
            begin
                if (b == qfed_pkg::CHAR_END || b == qfed_pkg::CHAR_AMP)
                begin
                    emit_next         = 1'b1;
                    match_status_next = qfed_pkg::ST_FOUND;
                end
                else if (b != qfed_pkg::CHAR_PCT)
                begin
                    emit_next = 1'b1;
                    if (full)
                    begin
                        match_status_next = qfed_pkg::ST_ERROR;
                    end
                    else
                    begin
                        result_kind_next = qfed_pkg::KIND_BYTE;
                        value_byte_next  = plain_byte;
                    end
                end
            end
            qfed_pkg::PH_ESC_HI:
            begin
                if (b == qfed_pkg::CHAR_END || !nib.ok)
                begin
                    emit_next         = 1'b1;
                    match_status_next = qfed_pkg::ST_ERROR;
                end
            end
            qfed_pkg::PH_ESC_LO:
            begin
                emit_next = 1'b1;
                if (b == qfed_pkg::CHAR_END || !nib.ok
                    || esc_byte == qfed_pkg::CHAR_END || full)
                begin
                    match_status_next = qfed_pkg::ST_ERROR;
                end
                else
                begin
                    result_kind_next = qfed_pkg::KIND_BYTE;
                    value_byte_next  = esc_byte;
                end
            end
            qfed_pkg::PH_DONE:
            begin
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_text_reg       <= '0;
            key_length_reg     <= '0;
            value_capacity_reg <= qfed_pkg::CAPACITY_RESET;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                qfed_pkg::REG_KEY_TEXT:       key_text_reg <= cfg_data[KEY_W-1:0];
                qfed_pkg::REG_KEY_LENGTH:     key_length_reg <= cfg_data[qfed_pkg::LENGTH_W-1:0];
                qfed_pkg::REG_VALUE_CAPACITY:
                    value_capacity_reg <= cfg_data[qfed_pkg::CAPACITY_W-1:0];
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg        <= qfed_pkg::PH_KEY;
            key_position_reg <= '0;
            key_mismatch_reg <= 1'b0;
            value_count_reg  <= '0;
            high_nibble_reg  <= '0;
        end
        else if (accept)
        begin
            phase_reg        <= phase_next;
            key_position_reg <= key_position_next;
            key_mismatch_reg <= key_mismatch_next;
            value_count_reg  <= value_count_next;
            high_nibble_reg  <= high_nibble_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_valid_reg <= 1'b0;
        end
        else if (accept)
        begin
            result_valid_reg <= emit_next;
        end
        else if (result.ready)
        begin
            result_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            result_kind_reg  <= result_kind_next;
            value_byte_reg   <= value_byte_next;
            match_status_reg <= match_status_next;
        end
    end

    // a pending value byte always leaves the parse inside the value
    assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid_reg && result_kind_reg == qfed_pkg::KIND_BYTE)
            |-> (phase_reg == qfed_pkg::PH_VALUE))
        else $error("value byte pending outside value phase");

    // a pending status word always leaves the parse finished or restarted
    assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid_reg && result_kind_reg == qfed_pkg::KIND_STATUS)
            |-> (phase_reg == qfed_pkg::PH_DONE || phase_reg == qfed_pkg::PH_KEY))
        else $error("status pending while parse still active");

    // the value counter is clear whenever a key is being scanned
    assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == qfed_pkg::PH_KEY || phase_reg == qfed_pkg::PH_SKIP)
            |-> (value_count_reg == '0))
        else $error("value count not cleared during key scan");

endmodule
`default_nettype wire
